// ----- rtl/gptw_pkg.sv -----
// Shared types, codes and constants for the guest page table walker.
`default_nettype none
package gptw_pkg;

    parameter int unsigned MEM_WORDS_DEF = 4096;
    parameter int unsigned DATA_W = 64;
    parameter int unsigned ADDR_W = 48;
    parameter int unsigned WIDX_W = 12;
    parameter int unsigned PAGE_SHIFT = 12;
    parameter int unsigned IDX_W = 9;
    parameter int unsigned BASE_W = ADDR_W - PAGE_SHIFT;
    parameter int unsigned BIT_P = 0;
    parameter int unsigned BIT_PS = 7;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic              valid;
        logic              fault;
        logic [ADDR_W-1:0] phys_addr;
    } t_walk_res;

endpackage
`default_nettype wire

// ----- rtl/gptw_if.sv -----
// Request and response channel interfaces of the guest page table walker.
`default_nettype none
interface gptw_req_if;
    logic                                valid;
    logic                                ready;
    logic                                command;
    logic [gptw_pkg::WIDX_W-1:0]         word_index;
    logic [gptw_pkg::DATA_W-1:0]         word_data;
    logic [gptw_pkg::DATA_W-1:0]         root_pointer;
    logic [gptw_pkg::ADDR_W-1:0]         virt_addr;

    modport source (output valid, command, word_index, word_data, root_pointer, virt_addr,
                    input ready);
    modport sink (input valid, command, word_index, word_data, root_pointer, virt_addr,
                  output ready);
endinterface

interface gptw_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gptw_pkg::ADDR_W-1:0] phys_addr;
    logic                        fault;

    modport source (output valid, phys_addr, fault, input ready);
    modport sink (input valid, phys_addr, fault, output ready);
endinterface
`default_nettype wire

// ----- rtl/gptw_ram.sv -----
// Generic single-port RAM with registered read data.
`default_nettype none
module gptw_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule
`default_nettype wire

// ----- rtl/gptw_walk.sv -----
// Walk sequencer with the shared index, address and offset-add unit.
`default_nettype none
module gptw_walk #(
    parameter int unsigned AW = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [gptw_pkg::BASE_W-1:0]   i_root_base,
    input  wire logic [gptw_pkg::ADDR_W-1:0]   i_va,
    input  wire logic [gptw_pkg::DATA_W-1:0]   i_rd_data,
    output logic      [AW-1:0]                 o_rd_addr,
    output logic                               o_busy,
    output gptw_pkg::t_walk_res                o_res
);

    localparam int unsigned FULL_W = gptw_pkg::BASE_W + gptw_pkg::IDX_W;

    gptw_pkg::t_state r_state, n_state;
    logic [1:0]                      r_lvl, n_lvl;
    logic [gptw_pkg::BASE_W-1:0]     r_base, n_base;
    logic [gptw_pkg::ADDR_W-1:0]     r_va, n_va;

    logic [1:0]                      sel_lvl;
    logic [gptw_pkg::BASE_W-1:0]     sel_base;
    logic [gptw_pkg::IDX_W-1:0]      idx;
    logic [FULL_W-1:0]               full_addr;
    logic [gptw_pkg::ADDR_W-1:0]     offset;
    logic [gptw_pkg::ADDR_W-1:0]     sum;
    logic [gptw_pkg::BASE_W-1:0]     entry_base;
    logic                            entry_zero;
    logic                            entry_p;
    logic                            entry_large;

    assign entry_base  = i_rd_data[gptw_pkg::ADDR_W-1:gptw_pkg::PAGE_SHIFT];
    assign entry_zero  = (i_rd_data == '0);
    assign entry_p     = i_rd_data[gptw_pkg::BIT_P];
    assign entry_large = i_rd_data[gptw_pkg::BIT_PS] && entry_p;

    always_comb begin
        case (sel_lvl)
            2'd3:    idx = r_va[39 +: gptw_pkg::IDX_W];
            2'd2:    idx = r_va[30 +: gptw_pkg::IDX_W];
            2'd1:    idx = r_va[21 +: gptw_pkg::IDX_W];
            default: idx = r_va[12 +: gptw_pkg::IDX_W];
        endcase
    end

    assign full_addr = {sel_base, idx};
    assign o_rd_addr = full_addr[AW-1:0];

    always_comb begin
        case (r_lvl)
            2'd3:    offset = {9'd0, r_va[38:0]};
            2'd2:    offset = {18'd0, r_va[29:0]};
            2'd1:    offset = {27'd0, r_va[20:0]};
            default: offset = {36'd0, r_va[11:0]};
        endcase
    end

    assign sum = {entry_base, 12'd0} + offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gptw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lvl  <= n_lvl;
        r_base <= n_base;
        r_va   <= n_va;
    end

    always_comb begin
        n_state         = r_state;
        n_lvl           = r_lvl;
        n_base          = r_base;
        n_va            = r_va;
        sel_lvl         = r_lvl;
        sel_base        = r_base;
        o_res.valid     = 1'b0;
        o_res.fault     = 1'b0;
        o_res.phys_addr = '0;
        case (r_state)
            gptw_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_va    = i_va;
                    n_base  = i_root_base;
                    n_lvl   = 2'd3;
                    n_state = gptw_pkg::ST_ISSUE;
                end
            end
            gptw_pkg::ST_ISSUE: begin
                n_state = gptw_pkg::ST_EVAL;
            end
            gptw_pkg::ST_EVAL: begin
                if (entry_zero || (r_lvl == 2'd0 && !entry_p)) begin
                    o_res.valid = 1'b1;
                    o_res.fault = 1'b1;
                    n_state     = gptw_pkg::ST_IDLE;
                end else if (r_lvl == 2'd0 || entry_large) begin
                    o_res.valid     = 1'b1;
                    o_res.phys_addr = sum;
                    n_state         = gptw_pkg::ST_IDLE;
                end else begin
                    sel_lvl  = r_lvl - 2'd1;
                    sel_base = entry_base;
                    n_lvl    = r_lvl - 2'd1;
                    n_base   = entry_base;
                end
            end
            default: begin
                n_state = gptw_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != gptw_pkg::ST_IDLE);

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.fault |-> o_res.phys_addr == '0)
        else $error("faulting result carries a nonzero address");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && r_state == gptw_pkg::ST_IDLE |=> r_state == gptw_pkg::ST_ISSUE && r_lvl == 2'd3)
        else $error("walk did not begin at the top level");

    a_descend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gptw_pkg::ST_EVAL && !o_res.valid |=>
            r_state == gptw_pkg::ST_EVAL && r_lvl == 2'($past(r_lvl) - 2'd1))
        else $error("walk did not descend one level");

    a_large_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.fault && r_lvl != 2'd0 |-> entry_large)
        else $error("early result without a large-page entry");

    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != gptw_pkg::ST_EVAL |-> !o_res.valid)
        else $error("result outside the evaluation state");

endmodule
`default_nettype wire

// ----- rtl/guest_page_table_walker_core.sv -----
// Top level of the guest page table walker: request intake, table memory and result register.
// A write item stores one 64-bit word into the table memory and gives no result. A translate
// item walks up to four table levels through the single memory port, one dependent read per
// level, so its result appears in the output register once the level that ends the walk has
// been read. A new item is taken once the walk is finished and the output register is free
// or being emptied. MEM_WORDS must be a power of two; word addresses wrap modulo MEM_WORDS.
// Table words that were never written read as undefined values.
`default_nettype none
module guest_page_table_walker_core #(
    parameter int unsigned MEM_WORDS = gptw_pkg::MEM_WORDS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    gptw_req_if.sink     i_req,
    gptw_rsp_if.source   o_rsp
);

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam int unsigned WIDX_EXT_W = (AW > gptw_pkg::WIDX_W) ? AW : gptw_pkg::WIDX_W;

    logic                          accept;
    logic                          wr_en;
    logic                          start;
    logic [WIDX_EXT_W-1:0]         widx_ext;
    logic [AW-1:0]                 walk_addr;
    logic [AW-1:0]                 ram_addr;
    logic [gptw_pkg::DATA_W-1:0]   ram_rdata;
    logic                          walk_busy;
    gptw_pkg::t_walk_res           walk_res;

    logic                          r_out_valid, n_out_valid;
    logic [gptw_pkg::ADDR_W-1:0]   r_out_phys, n_out_phys;
    logic                          r_out_fault, n_out_fault;

    assign i_req.ready = !walk_busy && (!r_out_valid || o_rsp.ready);
    assign accept      = i_req.valid && i_req.ready;
    assign wr_en       = accept && (i_req.command == gptw_pkg::CMD_WRITE);
    assign start       = accept && (i_req.command == gptw_pkg::CMD_XLATE);
    assign widx_ext    = WIDX_EXT_W'(i_req.word_index);
    assign ram_addr    = wr_en ? widx_ext[AW-1:0] : walk_addr;

    gptw_ram #(
        .WIDTH (gptw_pkg::DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_addr  (ram_addr),
        .i_wdata (i_req.word_data),
        .o_rdata (ram_rdata)
    );

    gptw_walk #(
        .AW (AW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_root_base (i_req.root_pointer[gptw_pkg::ADDR_W-1:gptw_pkg::PAGE_SHIFT]),
        .i_va        (i_req.virt_addr),
        .i_rd_data   (ram_rdata),
        .o_rd_addr   (walk_addr),
        .o_busy      (walk_busy),
        .o_res       (walk_res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_phys  = r_out_phys;
        n_out_fault = r_out_fault;
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (walk_res.valid) begin
            n_out_valid = 1'b1;
            n_out_phys  = walk_res.phys_addr;
            n_out_fault = walk_res.fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out_phys  <= n_out_phys;
        r_out_fault <= n_out_fault;
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.phys_addr = r_out_phys;
    assign o_rsp.fault     = r_out_fault;

endmodule
`default_nettype wire

// ----- tb/sv/guest_page_table_walker_core_tb.sv -----
// Self-checking testbench for the guest page table walker core.
`timescale 1ns / 100ps
module guest_page_table_walker_core_tb;

    localparam int unsigned MEM_WORDS = gptw_pkg::MEM_WORDS_DEF;
    localparam int unsigned DATA_W = gptw_pkg::DATA_W;
    localparam int unsigned ADDR_W = gptw_pkg::ADDR_W;
    localparam int unsigned WIDX_W = gptw_pkg::WIDX_W;
    localparam int unsigned BIT_P = gptw_pkg::BIT_P;
    localparam int unsigned BIT_PS = gptw_pkg::BIT_PS;

    localparam logic [63:0] ROOT_MASK = 64'h7fff_ffff_ffff_f000;
    localparam logic [63:0] BASE_MASK = 64'h0000_ffff_ffff_f000;
    localparam logic [63:0] SLOT_MASK = 64'h1ff;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned RSP_HOLD_CYCLES = 400;
    localparam int unsigned STALL_LIMIT = 5000;

    typedef struct {
        logic              command;
        logic [WIDX_W-1:0] word_index;
        logic [DATA_W-1:0] word_data;
        logic [DATA_W-1:0] root_pointer;
        logic [ADDR_W-1:0] virt_addr;
        bit                drain_first;
        bit                hold_rsp;
    } t_walk_req;

    typedef struct {
        logic [ADDR_W-1:0] phys_addr;
        logic              fault;
    } t_walk_res;

    class t_walk_scoreboard;
        logic [DATA_W-1:0] table_words [MEM_WORDS];
        t_walk_res         pending_q [$];
        int unsigned       mismatches;

        function void note_request(t_walk_req it);
            logic [DATA_W-1:0] base;
            logic [DATA_W-1:0] entry;
            logic [WIDX_W-1:0] slot;
            t_walk_res         want;
            int                lvl;
            bit                done;
            if (it.command == gptw_pkg::CMD_WRITE) begin
                table_words[it.word_index] = it.word_data;
                return;
            end
            done = 1'b0;
            want.phys_addr = '0;
            want.fault = 1'b1;
            base = it.root_pointer & ROOT_MASK;
            for (lvl = 4; lvl >= 1 && !done; lvl--) begin
                slot = WIDX_W'((base >> 3) + ((it.virt_addr >> (12 + 9 * (lvl - 1))) & SLOT_MASK));
                entry = table_words[slot];
                if (lvl == 1 ? entry[BIT_P] : (entry[BIT_P] && entry[BIT_PS])) begin
                    want.phys_addr = ADDR_W'((entry & BASE_MASK)
                        + (it.virt_addr & ((64'd1 << (12 + 9 * (lvl - 1))) - 1)));
                    want.fault = 1'b0;
                    done = 1'b1;
                end else if (lvl == 1 || entry == '0) begin
                    done = 1'b1;
                end else begin
                    base = entry & BASE_MASK;
                end
            end
            pending_q.push_back(want);
        endfunction

        function void check_result(logic [ADDR_W-1:0] phys_addr, logic fault);
            t_walk_res want;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result phys_addr=%h fault=%b", $time, phys_addr, fault);
                mismatches++;
                return;
            end
            want = pending_q.pop_front();
            if (phys_addr !== want.phys_addr) begin
                $display("%0t: phys_addr expected %h actual %h", $time, want.phys_addr, phys_addr);
                mismatches++;
            end
            if (fault !== want.fault) begin
                $display("%0t: fault expected %b actual %b", $time, want.fault, fault);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    gptw_req_if req_ch();
    gptw_rsp_if rsp_ch();

    guest_page_table_walker_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_walk_scoreboard  board;
    t_walk_req         send_q [$];
    logic [DATA_W-1:0] plan_words [MEM_WORDS];
    bit                plan_written [MEM_WORDS];
    bit                hold_rsp_req;

    function automatic t_walk_req rand_item(logic cmd);
        t_walk_req it;
        it.command = cmd;
        it.word_index = WIDX_W'($urandom);
        it.word_data = {$urandom, $urandom};
        it.root_pointer = {$urandom, $urandom};
        it.virt_addr = ADDR_W'({$urandom, $urandom});
        it.drain_first = 1'b0;
        it.hold_rsp = 1'b0;
        return it;
    endfunction

    // Queues a translation, first writing every table word the walk would read that holds
    // nothing yet. Fresh words are shaped so the walk ends at stop_lvl as a page or a fault.
    function automatic void plan_xlate(logic [DATA_W-1:0] root, logic [ADDR_W-1:0] va,
                                       int stop_lvl, bit to_fault, bit high_base);
        t_walk_req         it;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] entry;
        logic [WIDX_W-1:0] slot;
        int                lvl;
        bit                done;
        done = 1'b0;
        base = root & ROOT_MASK;
        for (lvl = 4; lvl >= 1 && !done; lvl--) begin
            slot = WIDX_W'((base >> 3) + ((va >> (12 + 9 * (lvl - 1))) & SLOT_MASK));
            if (!plan_written[slot]) begin
                entry = {$urandom, $urandom};
                if (high_base) begin
                    entry[47:12] = '1;
                end
                if (lvl == 1) begin
                    entry[BIT_P] = !to_fault;
                end else if (lvl <= stop_lvl && to_fault) begin
                    entry = '0;
                end else if (lvl <= stop_lvl) begin
                    entry[BIT_P] = 1'b1;
                    entry[BIT_PS] = 1'b1;
                end else begin
                    case ($urandom_range(0, 3))
                        0: entry[BIT_P] = 1'b0;
                        1: begin
                            entry[BIT_P] = 1'b0;
                            entry[BIT_PS] = 1'b0;
                        end
                        default: entry[BIT_PS] = 1'b0;
                    endcase
                    if (entry == '0) begin
                        entry[1] = 1'b1;
                    end
                end
                it = rand_item(gptw_pkg::CMD_WRITE);
                it.word_index = slot;
                it.word_data = entry;
                send_q.push_back(it);
                plan_words[slot] = entry;
                plan_written[slot] = 1'b1;
            end
            entry = plan_words[slot];
            if (lvl == 1 || entry == '0 || (entry[BIT_P] && entry[BIT_PS])) begin
                done = 1'b1;
            end else begin
                base = entry & BASE_MASK;
            end
        end
        it = rand_item(gptw_pkg::CMD_XLATE);
        it.root_pointer = root;
        it.virt_addr = va;
        send_q.push_back(it);
    endfunction

    function automatic void build_stimulus();
        t_walk_req         it;
        logic [DATA_W-1:0] root;
        logic [ADDR_W-1:0] va;
        logic [ADDR_W-1:0] va_seed;
        logic [ADDR_W-1:0] low_mask;
        int                stop_lvl;
        int                pick;
        int                first_random;
        bit                have_prev;
        it = rand_item(gptw_pkg::CMD_WRITE);
        it.word_index = '1;
        it.word_data = '1;
        send_q.push_back(it);
        plan_words[it.word_index] = it.word_data;
        plan_written[it.word_index] = 1'b1;
        it = rand_item(gptw_pkg::CMD_WRITE);
        it.word_index = '0;
        it.word_data = '0;
        send_q.push_back(it);
        plan_words[it.word_index] = it.word_data;
        plan_written[it.word_index] = 1'b1;
        plan_xlate('1, '1, 1, 1'b0, 1'b0);
        plan_xlate('0, '0, 1, 1'b0, 1'b0);
        root = {$urandom, $urandom};
        va_seed = ADDR_W'({$urandom, $urandom});
        for (stop_lvl = 1; stop_lvl <= 4; stop_lvl++) begin
            for (pick = 0; pick < 2; pick++) begin
                low_mask = ADDR_W'((64'd1 << (12 + 9 * stop_lvl)) - 1);
                va = (va_seed & ~low_mask) | (ADDR_W'({$urandom, $urandom}) & low_mask);
                plan_xlate(root, va, stop_lvl, pick[0], stop_lvl == 2 && pick == 0);
            end
        end

        first_random = send_q.size();
        have_prev = 1'b0;
        while (send_q.size() < first_random + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_q.push_back(rand_item(gptw_pkg::CMD_WRITE));
                it = send_q[send_q.size() - 1];
                plan_words[it.word_index] = it.word_data;
                plan_written[it.word_index] = 1'b1;
            end else begin
                if (pick < 55 && have_prev) begin
                    low_mask = ADDR_W'((64'd1 << (12 + 9 * $urandom_range(1, 3))) - 1);
                    va = (va & ~low_mask) | (ADDR_W'({$urandom, $urandom}) & low_mask);
                end else begin
                    root = {$urandom, $urandom};
                    va = ADDR_W'({$urandom, $urandom});
                end
                pick = $urandom_range(0, 19);
                stop_lvl = (pick < 11) ? 1 : (pick < 15) ? 2 : (pick < 18) ? 3 : 4;
                plan_xlate(root, va, stop_lvl, $urandom_range(0, 4) == 0,
                           $urandom_range(0, 15) == 0);
                have_prev = 1'b1;
            end
        end
        send_q[first_random].drain_first = 1'b1;
        send_q[first_random + 80].hold_rsp = 1'b1;
        send_q[first_random + RANDOM_ITEMS / 2].drain_first = 1'b1;
    endfunction

    task automatic send_all();
        int n;
        int gap;
        bit fast;
        fast = 1'b0;
        for (n = 0; n < send_q.size(); n++) begin
            if (n % 40 == 0) begin
                fast = ($urandom_range(0, 2) == 0);
            end
            gap = fast ? 0 : $urandom_range(0, 15);
            if (send_q[n].drain_first) begin
                gap = gap + 1;
            end
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                if (send_q[n].drain_first) begin
                    while (board.pending() != 0) @(posedge i_clk);
                end
                repeat (gap) @(posedge i_clk);
            end
            if (send_q[n].hold_rsp) begin
                hold_rsp_req = 1'b1;
            end
            req_ch.command <= send_q[n].command;
            req_ch.word_index <= send_q[n].word_index;
            req_ch.word_data <= send_q[n].word_data;
            req_ch.root_pointer <= send_q[n].root_pointer;
            req_ch.virt_addr <= send_q[n].virt_addr;
            req_ch.valid <= 1'b1;
            @(posedge i_clk);
            while (!req_ch.ready) @(posedge i_clk);
            board.note_request(send_q[n]);
        end
        req_ch.valid <= 1'b0;
    endtask

    initial begin
        int stall;
        int got;
        bit fast;
        got = 0;
        fast = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (got % 40 == 0) begin
                fast = ($urandom_range(0, 2) == 0);
            end
            if (hold_rsp_req) begin
                stall = RSP_HOLD_CYCLES;
                hold_rsp_req = 1'b0;
            end else begin
                stall = fast ? 0 : $urandom_range(0, 15);
            end
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            board.check_result(rsp_ch.phys_addr, rsp_ch.fault);
            got++;
        end
    end

    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        board = new();
        hold_rsp_req = 1'b0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.command <= gptw_pkg::CMD_WRITE;
        req_ch.word_index <= '0;
        req_ch.word_data <= '0;
        req_ch.root_pointer <= '0;
        req_ch.virt_addr <= '0;
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_all();
        while (board.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
